FILE: hdl/longest_prefix_match_router_assert.svh
// Assertion macros used by the route table datapath.
`ifndef LONGEST_PREFIX_MATCH_ROUTER_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_ROUTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lpm_pkg.sv
// Package with the types, codes and constants of the longest prefix match router.
package lpm_pkg;

  // Default table depth and the number of output interfaces.
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int IFACE_COUNT     = 16;
  localparam int MAX_LEN         = 32;

  // Item kinds.
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_ROUTE = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ADDED        = 3'd0,
    ST_FORWARDED    = 3'd1,
    ST_DROP_TTL     = 3'd2,
    ST_DROP_NOROUTE = 3'd3,
    ST_FULL         = 3'd4
  } lpm_status_t;

  // Input word.
  typedef struct packed {
    logic        action;
    logic [31:0] add_prefix;
    logic [5:0]  prefix_len;
    logic        hop_valid;
    logic [31:0] hop_addr;
    logic [3:0]  iface_index;
    logic [31:0] dest_addr;
    logic [7:0]  ttl_in;
  } lpm_in_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  out_iface;
    logic [31:0] next_hop_out;
    logic [7:0]  ttl_out;
  } lpm_out_t;

  // One stored route.
  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic        hop_valid;
    logic [31:0] hop;
    logic [3:0]  iface;
  } lpm_entry_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } lpm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic out_load;
  } lpm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } lpm_sts_t;

endpackage

FILE: hdl/lpm_ctrl.sv
// Controller state machine that sequences accept, table scan and result hand-off.
module lpm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output lpm_pkg::lpm_cmd_t cmd,
  input  lpm_pkg::lpm_sts_t sts
);

  lpm_pkg::lpm_state_t state_r;
  lpm_pkg::lpm_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_scan ? lpm_pkg::S_SCAN : lpm_pkg::S_FINISH;
        end
      end
      lpm_pkg::S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = lpm_pkg::S_LAST;
        end
      end
      lpm_pkg::S_LAST: begin
        state_nxt = lpm_pkg::S_FINISH;
      end
      lpm_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = lpm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lpm_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      lpm_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      lpm_pkg::S_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      lpm_pkg::S_LAST: begin
        cmd.rd_en = 1'b0;
      end
      lpm_pkg::S_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
    // No word is taken while reset is held.
    if (!rst_n) begin
      in_stall   = 1'b1;
      cmd.accept = 1'b0;
    end
  end

endmodule

FILE: hdl/lpm_datapath.sv
// Datapath with the route memory, the scan compare, the result logic and the output register.
`include "longest_prefix_match_router_assert.svh"

module lpm_datapath #(
  parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpm_pkg::lpm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lpm_pkg::lpm_out_t out_data,
  input  lpm_pkg::lpm_cmd_t cmd,
  output lpm_pkg::lpm_sts_t sts
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Mask of the high-order bits covered by a prefix length.
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else if (len >= 6'(lpm_pkg::MAX_LEN)) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = 32'hFFFF_FFFF << (6'(lpm_pkg::MAX_LEN) - len);
    end
    return m;
  endfunction

  lpm_pkg::lpm_entry_t mem [TABLE_DEPTH];
  lpm_pkg::lpm_entry_t rd_data_r;
  lpm_pkg::lpm_entry_t wr_entry;
  lpm_pkg::lpm_in_t    item_r;
  lpm_pkg::lpm_out_t   out_data_r;
  lpm_pkg::lpm_out_t   res;

  logic [CW-1:0] count_r;
  logic [AW-1:0] scan_idx_r;
  logic          rd_vld_r;
  logic          full;
  logic          wr_en;
  logic          add_full_r;
  logic          best_found_r;
  logic [5:0]    best_len_r;
  logic [3:0]    best_iface_r;
  logic          best_hop_valid_r;
  logic [31:0]   best_hop_r;
  logic          hit;
  logic          out_valid_r;

  assign full  = (count_r >= CW'(TABLE_DEPTH));
  assign wr_en = cmd.accept && (in_data.action == lpm_pkg::ACT_ADD) && !full;

  // Clamp length and interface before they are stored.
  always_comb begin
    wr_entry.prefix    = in_data.add_prefix;
    wr_entry.length    = (in_data.prefix_len > 6'(lpm_pkg::MAX_LEN)) ?
                         6'(lpm_pkg::MAX_LEN) : in_data.prefix_len;
    wr_entry.hop_valid = in_data.hop_valid;
    wr_entry.hop       = in_data.hop_addr;
    wr_entry.iface     = (32'(in_data.iface_index) >= 32'(lpm_pkg::IFACE_COUNT)) ?
                         4'(lpm_pkg::IFACE_COUNT - 1) : in_data.iface_index;
  end

  // Route memory: one write port at the fill count, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[scan_idx_r];
    end
  end

  // Fill count, scan index and read pipeline flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.accept) begin
        scan_idx_r <= '0;
      end else if (cmd.rd_en) begin
        scan_idx_r <= scan_idx_r + AW'(1);
      end
      rd_vld_r <= cmd.rd_en;
    end
  end

  // Item held for the duration of its work.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r     <= in_data;
      add_full_r <= full;
    end
  end

  // Compare the entry read last cycle against the destination.
  assign hit = (((item_r.dest_addr ^ rd_data_r.prefix) & len_mask(rd_data_r.length)) == 32'h0)
               && (rd_data_r.length >= best_len_r);

  // Best match so far; equal lengths let the later entry win.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
      best_len_r   <= '0;
    end else if (cmd.accept) begin
      best_found_r <= 1'b0;
      best_len_r   <= '0;
    end else if (rd_vld_r && hit) begin
      best_found_r <= 1'b1;
      best_len_r   <= rd_data_r.length;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && hit) begin
      best_iface_r     <= rd_data_r.iface;
      best_hop_valid_r <= rd_data_r.hop_valid;
      best_hop_r       <= rd_data_r.hop;
    end
  end

  // Result word from the finished item.
  always_comb begin
    res = '0;
    if (item_r.action == lpm_pkg::ACT_ADD) begin
      res.status = add_full_r ? lpm_pkg::ST_FULL : lpm_pkg::ST_ADDED;
    end else if (item_r.ttl_in <= 8'd1) begin
      res.status = lpm_pkg::ST_DROP_TTL;
    end else if (!best_found_r) begin
      res.status = lpm_pkg::ST_DROP_NOROUTE;
    end else begin
      res.status       = lpm_pkg::ST_FORWARDED;
      res.out_iface    = best_iface_r;
      res.next_hop_out = best_hop_valid_r ? best_hop_r : item_r.dest_addr;
      res.ttl_out      = item_r.ttl_in - 8'd1;
    end
  end

  // Output register: holds a word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status toward the controller.
  assign sts.need_scan = (in_data.action == lpm_pkg::ACT_ROUTE) && (in_data.ttl_in > 8'd1)
                         && (count_r != '0);
  assign sts.scan_last = (CW'(scan_idx_r) == (count_r - CW'(1)));
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Checks on the table and the result word.
  `LPM_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(TABLE_DEPTH), "fill count above depth")
  `LPM_ASSERT_IMPL(a_write_not_full, wr_en, !full, "write into a full table")
  `LPM_ASSERT_IMPL(a_load_free, cmd.out_load, !out_valid_r || !out_stall,
                   "output word overwritten while stalled")
  `LPM_ASSERT_IMPL(a_fwd_ttl, out_valid_r && (out_data_r.status == lpm_pkg::ST_FORWARDED),
                   out_data_r.ttl_out != 8'd0, "forwarded word with zero ttl")
  `LPM_ASSERT_NEXT(a_accept_clears, cmd.accept, !best_found_r && !rd_vld_r,
                   "scan state not cleared by a new item")

endmodule

FILE: hdl/longest_prefix_match_router.sv
// Top level of the IPv4 longest prefix match router.
//
// Input channel in_valid / in_stall / in_data carries one word per item: an add
// stores a route, a route item looks up a destination. Each item gives exactly
// one result word on out_valid / out_stall / out_data.
// A word moves when valid is high and stall is low at a rising clock edge.
// Items are handled one at a time. An add, a refused add, a TTL drop or a lookup
// in an empty table goes from acceptance straight to the finish state, where its
// word is loaded into the output register; the next item is then accepted in the
// idle state. A lookup reads one table entry per cycle from the route memory,
// scanning the N stored routes (up to TABLE_DEPTH), then compares the last entry
// read and loads its word. A new item can be accepted in the cycle after the
// previous result is loaded, even while that result is still stalled.
// When the receiver stalls, the output register holds its word and a finished
// item waits for it; input is stalled meanwhile.
// Reset (rst_n low, synchronous) stalls the input and empties the table by
// clearing the fill count; no clearing pass is needed, since only filled
// entries are ever read.
// Adds beyond TABLE_DEPTH entries are refused with the table full status.
module longest_prefix_match_router #(
  parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lpm_pkg::lpm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lpm_pkg::lpm_out_t out_data
);

  lpm_pkg::lpm_cmd_t cmd;
  lpm_pkg::lpm_sts_t sts;

  // Sequencer.
  lpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Route table and result path.
  lpm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: bench/longest_prefix_match_router_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the longest prefix match router: route adds and lookups.
module longest_prefix_match_router_test;

  localparam int RANDOM_ITEMS = 1525;
  localparam int CALM_ITEMS   = 200;
  localparam int PAUSE_AT     = 700;
  localparam int DRAIN_CYCLES = 100;
  localparam int HANG_LIMIT   = 1000;

  typedef struct {
    lpm_pkg::lpm_in_t  word;
    bit                typed;
    lpm_pkg::lpm_out_t result;
  } stim_row_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  lpm_pkg::lpm_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  lpm_pkg::lpm_out_t out_data;

  // Shadow copy of the route memory and its fill count.
  lpm_pkg::lpm_entry_t shadow_routes [lpm_pkg::TABLE_DEPTH_DEF];
  int unsigned         shadow_fill    = 0;
  lpm_pkg::lpm_out_t   pending_results [$];
  stim_row_t           directed_rows [$];
  int unsigned         mismatch_count = 0;
  int unsigned         hang_cycles    = 0;
  bit                  idle_en        = 1'b1;

  longest_prefix_match_router i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Network mask for a prefix length; zero length matches every address.
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    if (len == '0) return '0;
    if (len >= lpm_pkg::MAX_LEN) return '1;
    return 32'hFFFF_FFFF << (lpm_pkg::MAX_LEN - int'(len));
  endfunction

  // Computes the result of one word and updates the shadow route memory on an add.
  function automatic lpm_pkg::lpm_out_t forward_decision(input lpm_pkg::lpm_in_t w);
    lpm_pkg::lpm_out_t   res;
    lpm_pkg::lpm_entry_t e;
    bit                  found;
    int unsigned         best;
    int unsigned         best_len;
    int unsigned         i;
    res      = '0;
    found    = 1'b0;
    best     = 0;
    best_len = 0;
    if (w.action == lpm_pkg::ACT_ADD) begin
      if (shadow_fill >= lpm_pkg::TABLE_DEPTH_DEF) begin
        res.status = lpm_pkg::ST_FULL;
      end else begin
        e.prefix    = w.add_prefix;
        e.length    = (w.prefix_len > lpm_pkg::MAX_LEN) ? 6'(lpm_pkg::MAX_LEN)
                                                        : w.prefix_len;
        e.hop_valid = w.hop_valid;
        e.hop       = w.hop_addr;
        e.iface     = (int'(w.iface_index) >= lpm_pkg::IFACE_COUNT) ?
                      4'(lpm_pkg::IFACE_COUNT - 1) : w.iface_index;
        shadow_routes[shadow_fill] = e;
        shadow_fill++;
        res.status = lpm_pkg::ST_ADDED;
      end
    end else if (w.ttl_in <= 8'd1) begin
      res.status = lpm_pkg::ST_DROP_TTL;
    end else begin
      // Longest match wins; the later entry wins among equal lengths.
      for (i = 0; i < shadow_fill; i++) begin
        e = shadow_routes[i];
        if (((w.dest_addr ^ e.prefix) & len_mask(e.length)) == '0 &&
            int'(e.length) >= best_len) begin
          best_len = 32'(e.length);
          best     = i;
          found    = 1'b1;
        end
      end
      if (!found) begin
        res.status = lpm_pkg::ST_DROP_NOROUTE;
      end else begin
        e                = shadow_routes[best];
        res.status       = lpm_pkg::ST_FORWARDED;
        res.out_iface    = e.iface;
        res.next_hop_out = e.hop_valid ? e.hop : w.dest_addr;
        res.ttl_out      = w.ttl_in - 8'd1;
      end
    end
    return res;
  endfunction

  function automatic lpm_pkg::lpm_in_t add_word(input logic [31:0] prefix,
                                                input logic [5:0] len,
                                                input logic hv, input logic [31:0] hop,
                                                input logic [3:0] iface);
    lpm_pkg::lpm_in_t w;
    w             = '0;
    w.action      = lpm_pkg::ACT_ADD;
    w.add_prefix  = prefix;
    w.prefix_len  = len;
    w.hop_valid   = hv;
    w.hop_addr    = hop;
    w.iface_index = iface;
    return w;
  endfunction

  function automatic lpm_pkg::lpm_in_t route_word(input logic [31:0] dest,
                                                  input logic [7:0] ttl);
    lpm_pkg::lpm_in_t w;
    w           = '0;
    w.action    = lpm_pkg::ACT_ROUTE;
    w.dest_addr = dest;
    w.ttl_in    = ttl;
    return w;
  endfunction

  // A row whose result is plain enough to be written down directly.
  function automatic stim_row_t typed_row(input lpm_pkg::lpm_in_t w,
                                          input lpm_pkg::lpm_status_t st);
    stim_row_t r;
    r.word          = w;
    r.typed         = 1'b1;
    r.result        = '0;
    r.result.status = st;
    return r;
  endfunction

  function automatic stim_row_t check_row(input lpm_pkg::lpm_in_t w);
    stim_row_t r;
    r.word   = w;
    r.typed  = 1'b0;
    r.result = '0;
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void queue_row(input stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Random word: mostly lookups aimed at stored prefixes, adds nested in stored ones.
  function automatic lpm_pkg::lpm_in_t random_word();
    lpm_pkg::lpm_in_t    w;
    lpm_pkg::lpm_entry_t e;
    logic [31:0]         m;
    int unsigned         pick;
    w = {$urandom(), $urandom(), $urandom(), 20'($urandom())};
    if ($urandom_range(0, 9) < ((shadow_fill < lpm_pkg::TABLE_DEPTH_DEF) ? 3 : 1)) begin
      w.action = lpm_pkg::ACT_ADD;
      pick     = $urandom_range(0, 19);
      if (pick == 0) w.prefix_len = 6'($urandom_range(33, 63));
      else if (pick == 1) w.prefix_len = '0;
      else w.prefix_len = 6'($urandom_range(1, 32));
      if (shadow_fill != 0 && $urandom_range(0, 1) == 0) begin
        e = shadow_routes[$urandom_range(0, shadow_fill - 1)];
        m = len_mask(e.length);
        w.add_prefix = (e.prefix & m) | (w.add_prefix & ~m);
      end
    end else begin
      w.action = lpm_pkg::ACT_ROUTE;
      if (shadow_fill != 0 && $urandom_range(0, 3) != 0) begin
        e = shadow_routes[$urandom_range(0, shadow_fill - 1)];
        m = len_mask(e.length);
        w.dest_addr = (e.prefix & m) | (w.dest_addr & ~m);
        if ($urandom_range(0, 3) == 0) w.dest_addr ^= 32'd1 << $urandom_range(0, 31);
      end
      if ($urandom_range(0, 7) == 0) w.ttl_in = 8'($urandom_range(0, 1));
    end
    return w;
  endfunction

  // Offers one word, waits for it to be taken and records its expected result.
  task automatic send_word(input lpm_pkg::lpm_in_t w, input bit typed,
                           input lpm_pkg::lpm_out_t given);
    lpm_pkg::lpm_out_t predicted;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = forward_decision(w);
    pending_results.insert(pending_results.size(), typed ? given : predicted);
  endtask

  // Stimulus: directed rows, then random words, then drain.
  initial begin : stimulus
    int unsigned n;
    queue_row(typed_row(route_word(32'h0A00_0001, 8'd64), lpm_pkg::ST_DROP_NOROUTE));
    queue_row(typed_row(route_word(32'hFFFF_FFFF, 8'd0), lpm_pkg::ST_DROP_TTL));
    queue_row(typed_row(route_word(32'h0000_0000, 8'd1), lpm_pkg::ST_DROP_TTL));
    queue_row(typed_row(add_word(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0001, 4'd3),
                        lpm_pkg::ST_ADDED));
    queue_row(check_row(route_word(32'h0A01_0203, 8'd255)));
    queue_row(typed_row(add_word(32'h0A01_0000, 6'd16, 1'b0, 32'h0000_0000, 4'd15),
                        lpm_pkg::ST_ADDED));
    queue_row(check_row(route_word(32'h0A01_0203, 8'd2)));
    queue_row(check_row(route_word(32'h0A02_0000, 8'd100)));
    queue_row(typed_row(route_word(32'h0B00_0000, 8'd64), lpm_pkg::ST_DROP_NOROUTE));
    // Same prefix and length again: the later route must win.
    queue_row(typed_row(add_word(32'h0A01_0000, 6'd16, 1'b1, 32'h0102_0304, 4'd7),
                        lpm_pkg::ST_ADDED));
    queue_row(check_row(route_word(32'h0A01_FFFF, 8'd128)));
    // Length above 32 is treated as a full host route.
    queue_row(typed_row(add_word(32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd15),
                        lpm_pkg::ST_ADDED));
    queue_row(check_row(route_word(32'hFFFF_FFFF, 8'd255)));
    queue_row(check_row(route_word(32'hFFFF_FFFE, 8'd255)));
    // Host bits set below the length must be ignored by the match.
    queue_row(typed_row(add_word(32'hC0A8_01FF, 6'd24, 1'b0, 32'hFFFF_FFFF, 4'd0),
                        lpm_pkg::ST_ADDED));
    queue_row(check_row(route_word(32'hC0A8_0100, 8'd9)));
    queue_row(typed_row(add_word(32'h1234_5678, 6'd33, 1'b1, 32'h8765_4321, 4'd5),
                        lpm_pkg::ST_ADDED));
    queue_row(check_row(route_word(32'h1234_5678, 8'd3)));
    queue_row(check_row(route_word(32'h1234_5679, 8'd3)));
    // Default routes match every address; the second one takes over.
    queue_row(typed_row(add_word(32'hDEAD_BEEF, 6'd0, 1'b1, 32'hAAAA_AAAA, 4'd9),
                        lpm_pkg::ST_ADDED));
    queue_row(check_row(route_word(32'h0000_0000, 8'd255)));
    queue_row(check_row(route_word(32'h5555_5555, 8'd2)));
    queue_row(typed_row(add_word(32'h0000_0000, 6'd0, 1'b0, 32'h5555_5555, 4'd1),
                        lpm_pkg::ST_ADDED));
    queue_row(check_row(route_word(32'h0B00_0000, 8'd77)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].result);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_en <= 1'b0;
      // Hold off once until the router has returned every pending result.
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_word(random_word(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver back-pressure in short random bursts.
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    lpm_pkg::lpm_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word %h at %0t", out_data, $time);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.out_iface !== want.out_iface ||
            out_data.next_hop_out !== want.next_hop_out ||
            out_data.ttl_out !== want.ttl_out) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch at %0t (expected/actual): status %0d/%0d ",
                      "iface %0d/%0d hop %h/%h ttl %0d/%0d"}, $time,
                     want.status, out_data.status, want.out_iface, out_data.out_iface,
                     want.next_hop_out, out_data.next_hop_out,
                     want.ttl_out, out_data.ttl_out);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall == 1'b0)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

endmodule
